>>> rtl/mfp_pkg.sv
// Package for the message fragment packetizer: types, constants and the control program.
package mfp_pkg;

	localparam int BUF_DEPTH   = 32;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int HDR_LEN     = 24;
	localparam int CNT_W       = 6;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int STEP_W      = 4;
	localparam int ACC_W       = 42;

	localparam logic [7:0] HDR_CONST_A = 8'd32;
	localparam logic [7:0] HDR_CONST_B = 8'd64;
	localparam logic [CNT_W-1:0] HDR_LEN_C = CNT_W'(HDR_LEN);
	localparam logic [CNT_W-1:0] BUF_DEPTH_C = CNT_W'(BUF_DEPTH);

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PAYLOAD_SIZE  = 3'd0;
	localparam logic [2:0] REG_SOURCE        = 3'd1;
	localparam logic [2:0] REG_DESTINATION   = 3'd2;
	localparam logic [2:0] REG_FLAGS         = 3'd3;
	localparam logic [2:0] REG_MAX_FRAGMENTS = 3'd4;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  packet_byte;
		logic [15:0] packet_index;
		logic        last_in_packet;
		logic        last_of_message;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] payload_size;
		logic [39:0]      src_address;
		logic [39:0]      destination_address;
		logic [15:0]      header_flags;
		logic [15:0]      max_fragments;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MUL,
		OP_SUM1,
		OP_SUM2,
		OP_FOLD,
		OP_FIX,
		OP_EMIT_HDR,
		OP_EMIT_PAY
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_PKT,
		C_EMIT_DONE
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic  ready;
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic pkt_start;
		logic emit_done;
	} status_t;

	localparam step_t ST_WAIT = 4'd0;
	localparam step_t ST_MUL  = 4'd1;
	localparam step_t ST_SUM1 = 4'd2;
	localparam step_t ST_SUM2 = 4'd3;
	localparam step_t ST_FLD1 = 4'd4;
	localparam step_t ST_FLD2 = 4'd5;
	localparam step_t ST_FIX  = 4'd6;
	localparam step_t ST_HDR  = 4'd7;
	localparam step_t ST_PAY  = 4'd8;

	// The control program: when the condition holds, go to the target, otherwise stay.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '{ready: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: ST_WAIT};
		case (step)
			ST_WAIT: w = '{ready: 1'b1, op: OP_NOP,      cond: C_PKT,       target: ST_MUL};
			ST_MUL:  w = '{ready: 1'b0, op: OP_MUL,      cond: C_ALWAYS,    target: ST_SUM1};
			ST_SUM1: w = '{ready: 1'b0, op: OP_SUM1,     cond: C_ALWAYS,    target: ST_SUM2};
			ST_SUM2: w = '{ready: 1'b0, op: OP_SUM2,     cond: C_ALWAYS,    target: ST_FLD1};
			ST_FLD1: w = '{ready: 1'b0, op: OP_FOLD,     cond: C_ALWAYS,    target: ST_FLD2};
			ST_FLD2: w = '{ready: 1'b0, op: OP_FOLD,     cond: C_ALWAYS,    target: ST_FIX};
			ST_FIX:  w = '{ready: 1'b0, op: OP_FIX,      cond: C_ALWAYS,    target: ST_HDR};
			ST_HDR:  w = '{ready: 1'b0, op: OP_EMIT_HDR, cond: C_EMIT_DONE, target: ST_PAY};
			ST_PAY:  w = '{ready: 1'b0, op: OP_EMIT_PAY, cond: C_EMIT_DONE, target: ST_WAIT};
			default: w = '{ready: 1'b0, op: OP_NOP,      cond: C_ALWAYS,    target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/message_fragment_packetizer.sv
// Top level of the message fragment packetizer.
// Message words enter one per cycle while no packet is due. A word that completes the
// payload, or carries end_of_message, starts the control program: the header arithmetic
// steps (fragment offset multiply, checksum sum and two end-around folds modulo
// 2^32-1), then the 24 header bytes and the payload, one packet word per cycle while the
// output does not stall; no new message word is taken until the last payload word is emitted. The
// single output register lets the next message word enter while the last packet word is
// still waiting to be taken. Words arriving after max_fragments packets are dropped, and a
// dropped word marked end_of_message still ends the message.
module message_fragment_packetizer
	import mfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  in_word_t          msg,
	output logic              pkt_valid,
	input  logic              pkt_stall,
	output out_word_t         pkt
);

	cfg_t    cfg;
	ctrl_t   ctrl;
	status_t status;

	assign msg_stall = !ctrl.ready;

	mfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mfp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	mfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg),
		.msg_valid (msg_valid),
		.msg       (msg),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.status    (status)
	);

endmodule

>>> rtl/mfp_cfg.sv
// Configuration registers of the packetizer behind an APB-style port.
module mfp_cfg
	import mfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t        cfg_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_size        <= BUF_DEPTH_C;
			cfg_q.src_address         <= '0;
			cfg_q.destination_address <= '0;
			cfg_q.header_flags        <= '0;
			cfg_q.max_fragments       <= 16'hFFFF;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAYLOAD_SIZE:  cfg_q.payload_size        <= pwdata[CNT_W-1:0];
				REG_SOURCE:        cfg_q.src_address         <= pwdata[39:0];
				REG_DESTINATION:   cfg_q.destination_address <= pwdata[39:0];
				REG_FLAGS:         cfg_q.header_flags        <= pwdata[15:0];
				REG_MAX_FRAGMENTS: cfg_q.max_fragments       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAYLOAD_SIZE:  prdata = DATA_W'(cfg_q.payload_size);
			REG_SOURCE:        prdata = DATA_W'(cfg_q.src_address);
			REG_DESTINATION:   prdata = DATA_W'(cfg_q.destination_address);
			REG_FLAGS:         prdata = DATA_W'(cfg_q.header_flags);
			REG_MAX_FRAGMENTS: prdata = DATA_W'(cfg_q.max_fragments);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/mfp_seq.sv
// Step counter and control program lookup of the packetizer.
module mfp_seq
	import mfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t step_q;
	step_t step_next;
	logic  take;

	assign ctrl = ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:    take = 1'b1;
			C_PKT:       take = status.pkt_start;
			C_EMIT_DONE: take = status.emit_done;
			default:     take = 1'b1;
		endcase
		step_next = take ? ctrl.target : step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

>>> rtl/mfp_dp.sv
// Datapath of the packetizer: payload buffer, header arithmetic and output register.
module mfp_dp
	import mfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_t     ctrl,
	input  cfg_t      cfg,
	input  logic      msg_valid,
	input  in_word_t  msg,
	output logic      pkt_valid,
	input  logic      pkt_stall,
	output out_word_t pkt,
	output status_t   status
);

	logic [7:0]       buf_q [BUF_DEPTH];
	logic [CNT_W-1:0] fill_q;
	logic [15:0]      frag_q;
	logic             eom_q;
	logic [23:0]      offset_q;
	logic [ACC_W-1:0] acc_q;
	logic [31:0]      ck_q;
	logic [BUF_AW-1:0] k_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic [CNT_W-1:0] p_eff;
	logic             accept;
	logic             capped;
	logic [CNT_W-1:0] fill_inc;
	logic             pkt_start;
	logic [CNT_W-1:0] total;
	logic [7:0]       hdr_bytes [HDR_LEN];
	logic [191:0]     hdr_vec;
	logic             emit_op;
	logic             emit_go;
	logic             k_end;
	logic             last_byte;
	logic [15:0]      frag_inc;
	logic             last_msg;

	always_comb begin
		p_eff = cfg.payload_size;
		if (p_eff == '0) p_eff = CNT_W'(1);
		if (p_eff > BUF_DEPTH_C) p_eff = BUF_DEPTH_C;
	end

	assign accept    = ctrl.ready && msg_valid;
	assign capped    = frag_q >= cfg.max_fragments;
	assign fill_inc  = fill_q + CNT_W'(1);
	assign pkt_start = accept && !capped && (fill_inc >= p_eff || msg.end_of_message);
	assign total     = fill_q + HDR_LEN_C;

	assign hdr_vec = {cfg.src_address, cfg.destination_address, HDR_CONST_A, HDR_CONST_B,
		offset_q, cfg.header_flags, 18'd0, total, ck_q};

	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_bytes[i] = hdr_vec[191 - 8*i -: 8];
		end
	end

	assign emit_op  = (ctrl.op == OP_EMIT_HDR) || (ctrl.op == OP_EMIT_PAY);
	assign emit_go  = emit_op && (!out_valid_q || !pkt_stall);
	assign k_end    = (ctrl.op == OP_EMIT_HDR) ? (k_q == BUF_AW'(HDR_LEN - 1))
	                                           : ({1'b0, k_q} == fill_q - CNT_W'(1));
	assign last_byte = (ctrl.op == OP_EMIT_PAY) && k_end;
	assign frag_inc  = frag_q + 16'd1;
	assign last_msg  = eom_q || (frag_inc >= cfg.max_fragments);

	assign status.pkt_start = pkt_start;
	assign status.emit_done = emit_go && k_end;

	assign pkt_valid = out_valid_q;
	assign pkt       = out_q;

	// The fill count never exceeds the buffer depth less one between packets, so the
	// write index fits.
	always_ff @(posedge clk) begin
		if (accept && !capped) begin
			buf_q[fill_q[BUF_AW-1:0]] <= msg.message_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			frag_q      <= '0;
			eom_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (capped) begin
					if (msg.end_of_message) begin
						fill_q <= '0;
						frag_q <= '0;
					end
				end else if (pkt_start) begin
					fill_q <= (fill_inc > p_eff) ? p_eff : fill_inc;
					eom_q  <= msg.end_of_message;
				end else begin
					fill_q <= fill_inc;
				end
			end
			if (emit_go) begin
				if (k_end) begin
					k_q <= '0;
				end else begin
					k_q <= k_q + BUF_AW'(1);
				end
				if (last_byte) begin
					fill_q <= '0;
					frag_q <= eom_q ? 16'd0 : frag_inc;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!pkt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_MUL:  offset_q <= 24'(frag_q * p_eff);
			OP_SUM1: acc_q    <= ACC_W'(cfg.src_address) + ACC_W'(cfg.destination_address);
			OP_SUM2: acc_q    <= acc_q + ACC_W'(offset_q) + ACC_W'(cfg.header_flags)
			                     + ACC_W'(total) + ACC_W'(HDR_CONST_A) + ACC_W'(HDR_CONST_B);
			// 2^32 is one more than the modulus, so the upper bits fold back onto the lower.
			OP_FOLD: acc_q    <= ACC_W'(acc_q[ACC_W-1:32]) + ACC_W'(acc_q[31:0]);
			OP_FIX:  ck_q     <= (acc_q[31:0] == 32'hFFFF_FFFF) ? 32'd0 : acc_q[31:0];
			default: ;
		endcase
		if (emit_go) begin
			out_q.packet_byte     <= (ctrl.op == OP_EMIT_HDR) ? hdr_bytes[k_q] : buf_q[k_q];
			out_q.packet_index    <= frag_q;
			out_q.last_in_packet  <= last_byte;
			out_q.last_of_message <= last_byte && last_msg;
		end
	end

endmodule
